// File: sv/pfla_pkg.sv
`timescale 1ns / 1ps

package pfla_pkg;

  localparam int PAGE_W    = 12;
  localparam int COUNT_W   = 13;
  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int DATA_W    = 16;
  localparam int MAX_PAGES = 4096;

  localparam logic [COUNT_W-1:0] INITIAL_PAGES_RESET = 13'd2560;
  localparam logic [COUNT_W-1:0] MIN_FORMAT_PAGES    = 13'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_FORMAT = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  // finished result handed from the controller to the output register
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    status_t           status;
  } result_t;

endpackage

// File: sv/pfla_ram.sv
`timescale 1ns / 1ps

module pfla_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/pfla_ctrl.sv
`timescale 1ns / 1ps

module pfla_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pfla_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pfla_pkg::action_t            in_action,
  input  logic [pfla_pkg::PAGE_W-1:0]  in_page,
  output pfla_pkg::result_t            res,
  input  logic                         res_ready
);

  localparam int MAX_PAGES = pfla_pkg::MAX_PAGES;
  localparam int PW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_GROW,
    S_DONE
  } state_t;

  state_t                        state;
  logic [PW-1:0]                 free_head;
  logic [CW-1:0]                 page_count;
  logic [CW-1:0]                 fill_index;
  logic [CW-1:0]                 grow_target;
  logic                          grow_alloc;
  logic [pfla_pkg::COUNT_W-1:0]  initial_pages;
  logic [pfla_pkg::PAGE_W-1:0]   res_page;
  pfla_pkg::status_t             res_status;

  logic          accept;
  logic [CW:0]   dbl_count;
  logic [CW-1:0] alloc_target;
  logic [CW-1:0] format_target;
  logic          store_full;
  logic          free_bad;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] count_next;
  logic          walk_last;
  logic [PW-1:0] link_val;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic          ram_re;
  logic [PW-1:0] ram_rdata;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign dbl_count    = {page_count, 1'b0};
  assign alloc_target = (32'(dbl_count) > MAX_PAGES) ? CW'(MAX_PAGES) : dbl_count[CW-1:0];

  always_comb begin
    if (initial_pages < pfla_pkg::MIN_FORMAT_PAGES) begin
      format_target = CW'(pfla_pkg::MIN_FORMAT_PAGES);
    end else if (32'(initial_pages) > MAX_PAGES) begin
      format_target = CW'(MAX_PAGES);
    end else begin
      format_target = CW'(initial_pages);
    end
  end

  assign store_full = (32'(page_count) >= MAX_PAGES);
  assign free_bad   = (in_page == '0) || (32'(in_page) >= 32'(page_count));

  // grow walk: each page links to the next, the last one ends the list
  assign fill_next  = fill_index + CW'(1);
  assign count_next = page_count + CW'(1);
  assign walk_last  = (fill_next == grow_target);
  assign link_val   = walk_last ? '0 : PW'(fill_next);

  // writes come from a free or the grow walk, reads only from an alloc
  // pop; a pop never overlaps a write, so no forwarding is needed
  assign ram_we    = (accept && in_action == pfla_pkg::ACT_FREE && !free_bad) ||
                     (state == S_GROW);
  assign ram_waddr = (state == S_GROW) ? PW'(fill_index) : PW'(in_page);
  assign ram_wdata = (state == S_GROW) ? link_val : free_head;
  assign ram_re    = accept && in_action == pfla_pkg::ACT_ALLOC && free_head != '0;

  pfla_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (free_head),
    .rdata (ram_rdata)
  );

  assign res.valid  = (state == S_DONE);
  assign res.page   = res_page;
  assign res.status = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_head     <= '0;
      page_count    <= CW'(1);
      fill_index    <= '0;
      grow_target   <= '0;
      grow_alloc    <= 1'b0;
      initial_pages <= pfla_pkg::INITIAL_PAGES_RESET;
      res_page      <= '0;
      res_status    <= pfla_pkg::ST_OK;
    end else begin
      if (cfg_wr_en) begin
        initial_pages <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_page   <= '0;
            res_status <= pfla_pkg::ST_OK;
            unique case (in_action)
              pfla_pkg::ACT_ALLOC: begin
                if (free_head != '0) begin
                  res_page <= pfla_pkg::PAGE_W'(free_head);
                  state    <= S_POP;
                end else if (store_full) begin
                  res_status <= pfla_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  fill_index  <= page_count;
                  grow_target <= alloc_target;
                  grow_alloc  <= 1'b1;
                  state       <= S_GROW;
                end
              end
              pfla_pkg::ACT_FREE: begin
                if (free_bad) begin
                  res_status <= pfla_pkg::ST_BAD_FREE;
                end else begin
                  free_head <= PW'(in_page);
                end
                state <= S_DONE;
              end
              pfla_pkg::ACT_FORMAT: begin
                free_head   <= '0;
                page_count  <= CW'(1);
                fill_index  <= CW'(1);
                grow_target <= format_target;
                grow_alloc  <= 1'b0;
                state       <= S_GROW;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_POP: begin
          free_head <= ram_rdata;
          state     <= S_DONE;
        end
        S_GROW: begin
          fill_index <= fill_next;
          if (walk_last) begin
            page_count <= grow_target;
            if (grow_alloc) begin
              // pop the first new page right away, its link is known
              res_page  <= pfla_pkg::PAGE_W'(page_count);
              free_head <= (count_next == grow_target) ? '0 : PW'(count_next);
            end else begin
              free_head <= PW'(page_count);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/page_free_list_allocator_top.sv
`timescale 1ns / 1ps
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+----------------------------------------
// s_       | in        | s_tvalid/s_tready  | tuser: action; tdata: page, zero pad
// m_       | out       | m_tvalid/m_tready  | tuser: status; tdata: page_res, zero pad
// cfg_     | in        | cfg_wr_en          | cfg_wr_data: initial_pages
//
// free, failed alloc and no-op items go from idle straight to done; an alloc
// popped from the list passes through the pop state for the registered read
// of the link memory; a grow walk writes one link per cycle: an alloc on an
// empty list doubles the page count, at most MAX_PAGES, and a format links
// every page above the header, with initial_pages clamped to 2..MAX_PAGES
// synchronous reset gives an empty list with one page; the link memory is
// not cleared, every link is written before it is read
// one item at a time; a finished result waits in the output register while
// the next item is accepted, and the controller stalls only if it fills again

module page_free_list_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pfla_pkg::COUNT_W-1:0]  cfg_wr_data,  // initial_pages
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pfla_pkg::DATA_W-1:0]   s_tdata,      // [11:0] page
  input  logic [pfla_pkg::ACTION_W-1:0] s_tuser,      // [1:0] action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pfla_pkg::DATA_W-1:0]   m_tdata,      // [11:0] page_res
  output logic [pfla_pkg::STATUS_W-1:0] m_tuser       // [1:0] status
);

  pfla_pkg::result_t           res;
  logic                        res_ready;
  logic [pfla_pkg::PAGE_W-1:0] out_page;
  pfla_pkg::status_t           out_status;

  // output slot is free when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  pfla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_action   (pfla_pkg::action_t'(s_tuser)),
    .in_page     (s_tdata[pfla_pkg::PAGE_W-1:0]),
    .res         (res),
    .res_ready   (res_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      out_page   <= '0;
      out_status <= pfla_pkg::ST_OK;
    end else begin
      if (res.valid && res_ready) begin
        m_tvalid   <= 1'b1;
        out_page   <= res.page;
        out_status <= res.status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(pfla_pkg::DATA_W - pfla_pkg::PAGE_W)'(0), out_page};
  assign m_tuser = out_status;

endmodule

// File: sv/pfla_checker.sv
`timescale 1ns / 1ps

module pfla_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_wr_en,
  input logic [pfla_pkg::COUNT_W-1:0]  cfg_wr_data,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [pfla_pkg::DATA_W-1:0]   s_tdata,
  input logic [pfla_pkg::ACTION_W-1:0] s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pfla_pkg::DATA_W-1:0]   m_tdata,
  input logic [pfla_pkg::STATUS_W-1:0] m_tuser
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted back to back");

  // a failed item hands out no page
  a_fail_no_page: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == pfla_pkg::ST_FULL || m_tuser == pfla_pkg::ST_BAD_FREE)
      |-> m_tdata == '0)
    else $error("page returned with error status");

  // the padding stays zero and the status is a defined code
  a_page_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[pfla_pkg::DATA_W-1:pfla_pkg::PAGE_W] == '0 &&
                 m_tuser <= pfla_pkg::ST_BAD_FREE)
    else $error("bad result encoding");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind page_free_list_allocator_top pfla_checker u_pfla_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data),
  .s_tvalid    (s_tvalid),
  .s_tready    (s_tready),
  .s_tdata     (s_tdata),
  .s_tuser     (s_tuser),
  .m_tvalid    (m_tvalid),
  .m_tready    (m_tready),
  .m_tdata     (m_tdata),
  .m_tuser     (m_tuser)
);
